// ===== sv/pwst_pkg.sv =====
// ----------------------------------------------------------------------------
// pwst_pkg
// shared types and constants of the pulse-width single-wire transceiver
// ----------------------------------------------------------------------------
package pwst_pkg;

  // payload and register widths
  localparam int unsigned DATA_W    = 24;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MODE_W    = 3;

  // item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // link modes
  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TX_START = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TX_HIGH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TX_LOW   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RX_START = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RX_DATA  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RX_END   = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RX_START_MIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RX_START_MAX    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RX_ONE_MIN      = 3'd7;

  typedef struct packed {
    logic [TICK_W-1:0] start_low_ticks;
    logic [TICK_W-1:0] one_high_ticks;
    logic [TICK_W-1:0] zero_high_ticks;
    logic [TICK_W-1:0] one_low_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] rx_start_min;
    logic [TICK_W-1:0] rx_start_max;
    logic [TICK_W-1:0] rx_one_min;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    start_low_ticks: 8'd100,
    one_high_ticks:  8'd10,
    zero_high_ticks: 8'd5,
    one_low_ticks:   8'd5,
    zero_low_ticks:  8'd10,
    rx_start_min:    8'd80,
    rx_start_max:    8'd150,
    rx_one_min:      8'd8
  };

endpackage

// ===== sv/pulse_width_single_wire_transceiver_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_width_single_wire_transceiver_unit
// half-duplex pulse-width coded single-wire link, stepped once per tick beat
// ----------------------------------------------------------------------------
// each result beat is registered, in the cycle after its input is accepted
// throughput: one input beat per cycle unless a held result stalls input;
//   link update is one counter/compare pass, handshake to result register
// reset (rst, synchronous, active high): link idle, counters and shift
//   registers zero, config registers at their default tick counts
module pulse_width_single_wire_transceiver_unit #(
  parameter int unsigned SEND_BYTES   = 3,
  parameter int unsigned RECV_BYTES   = 3,
  parameter int unsigned ONE_HIGH_MAX = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  // input beats: ticks and start requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic                              line_level,
  input  logic [pwst_pkg::DATA_W-1:0]       send_bytes,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              line_drive,
  output logic                              start_taken,
  output logic                              link_busy,
  output logic                              frame_done,
  output logic [pwst_pkg::DATA_W-1:0]       recv_bytes,
  // config writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwst_pkg::TICK_W-1:0]       cfg_data
);

  // byte counts compare against a 3-bit count of 1..4 done bytes
  localparam logic [3:0] SEND_BYTES_W = 4'(SEND_BYTES);
  localparam logic [3:0] RECV_BYTES_W = 4'(RECV_BYTES);
  localparam logic [pwst_pkg::TICK_W-1:0] ONE_HIGH_MAX_W = pwst_pkg::TICK_W'(ONE_HIGH_MAX);
  localparam logic [pwst_pkg::POS_W-1:0]  POS_LIMIT      = pwst_pkg::POS_W'(pwst_pkg::DATA_W);

  // config registers
  pwst_pkg::cfg_regs_t cfg;

  // link state
  logic [pwst_pkg::MODE_W-1:0] mode, mode_next;
  logic [pwst_pkg::TICK_W-1:0] phase_ticks, phase_ticks_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [1:0]                  byte_index, byte_index_next;
  logic [pwst_pkg::DATA_W-1:0] send_shift, send_shift_next;
  logic [pwst_pkg::DATA_W-1:0] recv_shift, recv_shift_next;
  logic                        prior_level, prior_level_next;
  logic                        taken_next, done_next;

  logic                        accept;
  logic [pwst_pkg::TICK_W-1:0] ticks_inc;
  logic [pwst_pkg::POS_W-1:0]  pos;
  logic                        pos_valid;
  logic                        send_bit;
  logic                        byte_wrap;
  logic [2:0]                  byte_count;
  logic [2:0]                  bit_adv;
  logic [1:0]                  byte_adv;
  logic                        tx_last;
  logic                        rx_last;
  logic [pwst_pkg::TICK_W-1:0] tx_high_lim;
  logic [pwst_pkg::TICK_W-1:0] tx_low_lim;

  // the result register frees up when it is empty or drained this cycle
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // saturating tick count
  assign ticks_inc = (phase_ticks == {pwst_pkg::TICK_W{1'b1}}) ? phase_ticks
                                                              : phase_ticks + 1'b1;

  // bit position byte*8+bit, lsb first
  assign pos       = {byte_index, bit_index};
  assign pos_valid = pos < POS_LIMIT;
  assign send_bit  = pos_valid ? send_shift[pos] : 1'b0;

  // bit/byte advance shared by sender and receiver
  assign byte_wrap  = bit_index == 3'd7;
  assign byte_count = {1'b0, byte_index} + 3'd1;
  assign bit_adv    = bit_index + 3'd1;
  assign byte_adv   = byte_wrap ? byte_count[1:0] : byte_index;
  assign tx_last    = byte_wrap & (({1'b0, byte_count} >= SEND_BYTES_W) | byte_count[2]);
  assign rx_last    = byte_wrap & (({1'b0, byte_count} >= RECV_BYTES_W) | byte_count[2]);

  // phase lengths of the bit being sent
  assign tx_high_lim = send_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign tx_low_lim  = send_bit ? cfg.one_low_ticks  : cfg.zero_low_ticks;

  always_comb begin
    mode_next        = mode;
    phase_ticks_next = phase_ticks;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    send_shift_next  = send_shift;
    recv_shift_next  = recv_shift;
    prior_level_next = prior_level;
    taken_next       = 1'b0;
    done_next        = 1'b0;

    if (opcode == pwst_pkg::OP_START) begin
      // a request is only taken on an idle link and takes no tick
      if (mode == pwst_pkg::MODE_IDLE) begin
        send_shift_next  = send_bytes;
        byte_index_next  = 2'd0;
        bit_index_next   = 3'd0;
        phase_ticks_next = '0;
        mode_next        = pwst_pkg::MODE_TX_START;
        taken_next       = 1'b1;
      end
    end else begin
      unique case (mode)
        pwst_pkg::MODE_TX_START: begin
          if (ticks_inc >= cfg.start_low_ticks) begin
            phase_ticks_next = '0;
            mode_next        = pwst_pkg::MODE_TX_HIGH;
          end else begin
            phase_ticks_next = ticks_inc;
          end
        end
        pwst_pkg::MODE_TX_HIGH: begin
          if (ticks_inc >= tx_high_lim) begin
            phase_ticks_next = '0;
            mode_next        = pwst_pkg::MODE_TX_LOW;
          end else begin
            phase_ticks_next = ticks_inc;
          end
        end
        pwst_pkg::MODE_TX_LOW: begin
          if (ticks_inc >= tx_low_lim) begin
            phase_ticks_next = '0;
            bit_index_next   = bit_adv;
            byte_index_next  = byte_adv;
            mode_next        = tx_last ? pwst_pkg::MODE_IDLE : pwst_pkg::MODE_TX_HIGH;
          end else begin
            phase_ticks_next = ticks_inc;
          end
        end
        pwst_pkg::MODE_IDLE: begin
          // wire pulled low by the far end: start pulse begins
          if (!line_level) begin
            phase_ticks_next = '0;
            mode_next        = pwst_pkg::MODE_RX_START;
            byte_index_next  = 2'd0;
            bit_index_next   = 3'd0;
            recv_shift_next  = '0;
          end
          prior_level_next = line_level;
        end
        pwst_pkg::MODE_RX_START: begin
          phase_ticks_next = ticks_inc;
          if (line_level) begin
            if ((ticks_inc >= cfg.rx_start_min) && (ticks_inc <= cfg.rx_start_max)) begin
              phase_ticks_next = '0;
              mode_next        = pwst_pkg::MODE_RX_DATA;
            end else begin
              mode_next = pwst_pkg::MODE_IDLE;
            end
          end
          prior_level_next = line_level;
        end
        pwst_pkg::MODE_RX_DATA: begin
          phase_ticks_next = ticks_inc;
          if (line_level != prior_level) begin
            // a falling edge closes a high phase: decode it by its length
            if (prior_level) begin
              if ((ticks_inc >= cfg.rx_one_min) && (ticks_inc <= ONE_HIGH_MAX_W) &&
                  pos_valid) begin
                recv_shift_next[pos] = 1'b1;
              end
              bit_index_next  = bit_adv;
              byte_index_next = byte_adv;
              if (rx_last) begin
                mode_next = pwst_pkg::MODE_RX_END;
                done_next = 1'b1;
              end
            end
            phase_ticks_next = '0;
          end
          prior_level_next = line_level;
        end
        default: begin
          // rx end and unused codes fall back to idle
          mode_next        = pwst_pkg::MODE_IDLE;
          prior_level_next = line_level;
        end
      endcase
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pwst_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwst_pkg::REG_START_LOW_TICKS: cfg.start_low_ticks <= cfg_data;
        pwst_pkg::REG_ONE_HIGH_TICKS:  cfg.one_high_ticks  <= cfg_data;
        pwst_pkg::REG_ZERO_HIGH_TICKS: cfg.zero_high_ticks <= cfg_data;
        pwst_pkg::REG_ONE_LOW_TICKS:   cfg.one_low_ticks   <= cfg_data;
        pwst_pkg::REG_ZERO_LOW_TICKS:  cfg.zero_low_ticks  <= cfg_data;
        pwst_pkg::REG_RX_START_MIN:    cfg.rx_start_min    <= cfg_data;
        pwst_pkg::REG_RX_START_MAX:    cfg.rx_start_max    <= cfg_data;
        pwst_pkg::REG_RX_ONE_MIN:      cfg.rx_one_min      <= cfg_data;
        default: ;
      endcase
    end
  end

  // link state advances on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= pwst_pkg::MODE_IDLE;
      phase_ticks <= '0;
      bit_index   <= '0;
      byte_index  <= '0;
      send_shift  <= '0;
      recv_shift  <= '0;
      prior_level <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      phase_ticks <= phase_ticks_next;
      bit_index   <= bit_index_next;
      byte_index  <= byte_index_next;
      send_shift  <= send_shift_next;
      recv_shift  <= recv_shift_next;
      prior_level <= prior_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload holds while stalled since accept is low then
  always_ff @(posedge clk) begin
    if (accept) begin
      // wire is pulled low during the start pulse and every low phase
      line_drive  <= ~((mode_next == pwst_pkg::MODE_TX_START) ||
                       (mode_next == pwst_pkg::MODE_TX_LOW));
      start_taken <= taken_next;
      link_busy   <= mode_next != pwst_pkg::MODE_IDLE;
      frame_done  <= done_next;
      recv_bytes  <= recv_shift_next;
    end
  end

endmodule

// ===== sv/pwst_checker.sv =====
// ----------------------------------------------------------------------------
// pwst_checker
// port-level checks of the pulse-width single-wire transceiver
// ----------------------------------------------------------------------------
module pwst_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           line_drive,
  input logic                           start_taken,
  input logic                           link_busy,
  input logic                           frame_done,
  input logic [pwst_pkg::DATA_W-1:0]    recv_bytes
);

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a taken start puts the link into the low start pulse
  a_start_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_taken) |-> (link_busy && !line_drive))
    else $error("start taken but link not driving start pulse");

  // a finished frame leaves the link busy for one end tick, wire released
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> (link_busy && line_drive && !start_taken))
    else $error("frame done with inconsistent link status");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(recv_bytes) &&
                                  $stable(frame_done) && $stable(line_drive)))
    else $error("stalled result beat changed");

endmodule

bind pulse_width_single_wire_transceiver_unit pwst_checker u_pwst_checker (.*);

// ===== sim/tb_pulse_width_single_wire_transceiver_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pulse_width_single_wire_transceiver_unit
// self-checking bench: tick and start-request beats go in, every result beat
// is compared against an in-bench model of the link, over several timing
// setups with random idling on both channels
// ----------------------------------------------------------------------------
module tb_pulse_width_single_wire_transceiver_unit;
  import pwst_pkg::*;

  // block parameters, kept at their defaults
  localparam int TX_BYTES     = 3;
  localparam int RX_BYTES     = 3;
  localparam int ONE_HIGH_MAX = 12;

  // one result beat as the block presents it
  typedef struct packed {
    logic              drive;
    logic              taken;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] bytes;
  } link_beat_t;

  // a row of the directed table: the fixed beat is used only where has_want is set
  typedef struct {
    logic              op;
    logic              lvl;
    logic [DATA_W-1:0] data;
    bit                has_want;
    link_beat_t        want;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              opcode;
  logic              line_level;
  logic [DATA_W-1:0] send_bytes;
  logic              out_valid;
  logic              out_stall;
  logic              line_drive;
  logic              start_taken;
  logic              link_busy;
  logic              frame_done;
  logic [DATA_W-1:0] recv_bytes;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0] cfg_data;

  pulse_width_single_wire_transceiver_unit #(
    .SEND_BYTES  (TX_BYTES),
    .RECV_BYTES  (RX_BYTES),
    .ONE_HIGH_MAX(ONE_HIGH_MAX)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .line_level (line_level),
    .send_bytes (send_bytes),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_drive (line_drive),
    .start_taken(start_taken),
    .link_busy  (link_busy),
    .frame_done (frame_done),
    .recv_bytes (recv_bytes),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // link model: timing registers and link state as the block should hold them
  // ---------------------------------------------------------------------------
  cfg_regs_t         link_cfg;
  logic [MODE_W-1:0] lk_mode;
  logic [TICK_W-1:0] lk_ticks;
  logic [2:0]        lk_bit;
  logic [1:0]        lk_byte;
  logic [DATA_W-1:0] lk_tx_sr;
  logic [DATA_W-1:0] lk_rx_sr;
  logic              lk_prior;

  // result beats still owed by the block, oldest first
  link_beat_t due_results[$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  tx_idle_pct  = 0;
  int  rx_stall_pct = 0;
  logic hold_req    = 1'b0;
  bit  hold_used    = 1'b0;
  int  hold_left    = 0;

  function automatic void reset_link();
    link_cfg = CFG_RESET;
    lk_mode  = MODE_IDLE;
    lk_ticks = '0;
    lk_bit   = '0;
    lk_byte  = '0;
    lk_tx_sr = '0;
    lk_rx_sr = '0;
    lk_prior = 1'b0;
  endfunction

  // phase counter stops at 255 instead of wrapping
  function automatic void bump_ticks();
    if (lk_ticks != 8'hFF) lk_ticks = lk_ticks + 8'd1;
  endfunction

  function automatic int bit_pos();
    return int'(lk_byte) * 8 + int'(lk_bit);
  endfunction

  // bits past the 24-bit register go out as zero
  function automatic logic tx_bit();
    int pos;
    pos = bit_pos();
    return (pos < DATA_W) ? lk_tx_sr[pos] : 1'b0;
  endfunction

  // step to the next bit; true once the frame is complete
  function automatic bit next_bit(input int nbytes);
    int nb;
    if (lk_bit == 3'd7) begin
      nb      = int'(lk_byte) + 1;
      lk_bit  = '0;
      lk_byte = nb[1:0];
      return (nb >= nbytes) || (nb >= 4);
    end
    lk_bit = lk_bit + 3'd1;
    return 1'b0;
  endfunction

  // one accepted input beat through the link; returns the result beat it causes
  function automatic link_beat_t link_step(input logic op, input logic lvl,
                                           input logic [DATA_W-1:0] data);
    link_beat_t r;
    int         lim;
    int         pos;
    r = '0;
    if (op == OP_START) begin
      // a request while busy is dropped and takes no tick
      if (lk_mode == MODE_IDLE) begin
        lk_tx_sr = data;
        lk_byte  = '0;
        lk_bit   = '0;
        lk_ticks = '0;
        lk_mode  = MODE_TX_START;
        r.taken  = 1'b1;
      end
    end else begin
      case (lk_mode)
        MODE_TX_START: begin
          bump_ticks();
          if (lk_ticks >= link_cfg.start_low_ticks) begin
            lk_ticks = '0;
            lk_mode  = MODE_TX_HIGH;
          end
        end
        MODE_TX_HIGH: begin
          lim = tx_bit() ? link_cfg.one_high_ticks : link_cfg.zero_high_ticks;
          bump_ticks();
          if (lk_ticks >= lim) begin
            lk_ticks = '0;
            lk_mode  = MODE_TX_LOW;
          end
        end
        MODE_TX_LOW: begin
          lim = tx_bit() ? link_cfg.one_low_ticks : link_cfg.zero_low_ticks;
          bump_ticks();
          if (lk_ticks >= lim) begin
            lk_ticks = '0;
            lk_mode  = next_bit(TX_BYTES) ? MODE_IDLE : MODE_TX_HIGH;
          end
        end
        default: begin
          // receive side: the wire is only sampled here
          case (lk_mode)
            MODE_IDLE: begin
              if (!lvl) begin
                lk_ticks = '0;
                lk_mode  = MODE_RX_START;
                lk_byte  = '0;
                lk_bit   = '0;
                lk_rx_sr = '0;
              end
            end
            MODE_RX_START: begin
              bump_ticks();
              if (lvl) begin
                if (lk_ticks >= link_cfg.rx_start_min && lk_ticks <= link_cfg.rx_start_max)
                begin
                  lk_ticks = '0;
                  lk_mode  = MODE_RX_DATA;
                end else begin
                  lk_mode = MODE_IDLE;
                end
              end
            end
            MODE_RX_DATA: begin
              bump_ticks();
              if (lvl != lk_prior) begin
                // falling edge closes a high phase: time it
                if (lk_prior) begin
                  if (lk_ticks >= link_cfg.rx_one_min && lk_ticks <= ONE_HIGH_MAX) begin
                    pos = bit_pos();
                    if (pos < DATA_W) lk_rx_sr[pos] = 1'b1;
                  end
                  if (next_bit(RX_BYTES)) begin
                    lk_mode = MODE_RX_END;
                    r.done  = 1'b1;
                  end
                end
                lk_ticks = '0;
              end
            end
            default: lk_mode = MODE_IDLE;
          endcase
          lk_prior = lvl;
        end
      endcase
    end
    r.drive = !(lk_mode == MODE_TX_START || lk_mode == MODE_TX_LOW);
    r.busy  = (lk_mode != MODE_IDLE);
    r.bytes = lk_rx_sr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // payloads lean on all-zero and all-one patterns
  function automatic logic [DATA_W-1:0] rand_bytes();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // short tx phases keep frames brief; rx windows stay small too
  function automatic cfg_regs_t short_timing_cfg();
    cfg_regs_t c;
    c.start_low_ticks = $urandom_range(1, 6);
    c.one_high_ticks  = $urandom_range(1, 6);
    c.zero_high_ticks = $urandom_range(1, 6);
    c.one_low_ticks   = $urandom_range(1, 6);
    c.zero_low_ticks  = $urandom_range(1, 6);
    c.rx_start_min    = $urandom_range(1, 8);
    c.rx_start_max    = c.rx_start_min + $urandom_range(0, 8);
    c.rx_one_min      = $urandom_range(1, 13);
    return c;
  endfunction

  // offer one beat, wait for the handshake, log what the block owes for it,
  // then maybe leave the channel idle for a while
  task automatic send_item(input logic op, input logic lvl, input logic [DATA_W-1:0] data,
                           input bit has_want = 1'b0, input link_beat_t want = '0);
    link_beat_t got;
    in_valid   <= 1'b1;
    opcode     <= op;
    line_level <= lvl;
    send_bytes <= data;
    do @(posedge clk); while (in_stall);
    got = link_step(op, lvl, data);
    due_results.push_back(has_want ? want : got);
    if (op == OP_TICK || got.taken) items_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  // tick until the link is idle: a sender runs out, a receiver is fed edges
  task automatic settle_link();
    while (lk_mode != MODE_IDLE)
      send_item(OP_TICK, (lk_mode == MODE_RX_DATA) ? ~lk_prior : 1'b1, rand_bytes());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_LOW_TICKS: link_cfg.start_low_ticks = val;
      REG_ONE_HIGH_TICKS:  link_cfg.one_high_ticks  = val;
      REG_ZERO_HIGH_TICKS: link_cfg.zero_high_ticks = val;
      REG_ONE_LOW_TICKS:   link_cfg.one_low_ticks   = val;
      REG_ZERO_LOW_TICKS:  link_cfg.zero_low_ticks  = val;
      REG_RX_START_MIN:    link_cfg.rx_start_min    = val;
      REG_RX_START_MAX:    link_cfg.rx_start_max    = val;
      default:             link_cfg.rx_one_min      = val;
    endcase
  endtask

  // registers change only with no beat in flight and the link idle
  task automatic load_cfg(input cfg_regs_t c);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_START_LOW_TICKS, c.start_low_ticks);
    write_reg(REG_ONE_HIGH_TICKS,  c.one_high_ticks);
    write_reg(REG_ZERO_HIGH_TICKS, c.zero_high_ticks);
    write_reg(REG_ONE_LOW_TICKS,   c.one_low_ticks);
    write_reg(REG_ZERO_LOW_TICKS,  c.zero_low_ticks);
    write_reg(REG_RX_START_MIN,    c.rx_start_min);
    write_reg(REG_RX_START_MAX,    c.rx_start_max);
    write_reg(REG_RX_ONE_MIN,      c.rx_one_min);
    cfg_valid <= 1'b0;
  endtask

  // a received frame: start pulse near the window, then high/low bit phases
  // timed around the one-window; start_len of zero picks the pulse length
  task automatic rx_frame(input int start_len);
    int n;
    int h;
    int l;
    int b;
    int lo_w;
    int hi_w;
    int one_lo;
    settle_link();
    repeat ($urandom_range(0, 2)) send_item(OP_TICK, 1'b1, rand_bytes());
    lo_w   = (link_cfg.rx_start_min == 0) ? 1 : link_cfg.rx_start_min;
    hi_w   = link_cfg.rx_start_max;
    one_lo = (link_cfg.rx_one_min == 0) ? 1 : link_cfg.rx_one_min;
    n      = start_len;
    if (n == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    n = (lo_w <= hi_w) ? $urandom_range(lo_w, hi_w) : $urandom_range(1, 25);
        2:       n = (lo_w > 1) ? lo_w - 1 : 1;
        3:       n = hi_w + 1;  // past the window, saturates when max is 255
        default: n = $urandom_range(1, hi_w + 4);
      endcase
    end
    repeat (n) send_item(OP_TICK, 1'b0, rand_bytes());
    b = 0;
    do begin
      case ($urandom_range(0, 5))
        0, 1:    h = $urandom_range(one_lo, ONE_HIGH_MAX);
        2:       h = $urandom_range(1, one_lo);
        3:       h = (one_lo > 1) ? one_lo - 1 : 1;
        4:       h = ONE_HIGH_MAX + $urandom_range(1, 2);
        default: h = $urandom_range(1, 20);
      endcase
      if (h > 40) h = 40;
      l = $urandom_range(1, 3);
      repeat (h) begin
        // stray request in the middle of a frame, dropped while busy
        if (lk_mode != MODE_IDLE && $urandom_range(0, 99) < 3)
          send_item(OP_START, 1'b1, rand_bytes());
        send_item(OP_TICK, 1'b1, rand_bytes());
      end
      repeat (l) send_item(OP_TICK, 1'b0, rand_bytes());
      b++;
    end while (lk_mode == MODE_RX_DATA && b < 30);
  endtask

  // a sent frame; the wire level is noise since it is not sampled while sending
  task automatic tx_frame(input logic [DATA_W-1:0] data);
    settle_link();
    send_item(OP_START, $urandom_range(0, 1), data);
    while (lk_mode != MODE_IDLE) begin
      if ($urandom_range(0, 99) < 3) send_item(OP_START, $urandom_range(0, 1), rand_bytes());
      else send_item(OP_TICK, $urandom_range(0, 1), rand_bytes());
    end
  endtask

  // mostly whole frames, some loose beats
  task automatic run_phase(input int budget);
    int r;
    items_sent = 0;
    while (items_sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 45) rx_frame(0);
      else if (r < 75) tx_frame(rand_bytes());
      else begin
        repeat ($urandom_range(1, 12))
          send_item(($urandom_range(0, 9) == 0) ? OP_START : OP_TICK,
                    $urandom_range(0, 1), rand_bytes());
      end
    end
    settle_link();
  endtask

  // ---------------------------------------------------------------------------
  // directed table, run at the reset timing
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [11] = '{
    // idle with the wire high: nothing happens
    '{OP_TICK,  1'b1, 24'h000000, 1'b1, {1'b1, 1'b0, 1'b0, 1'b0, 24'h000000}},
    // wire low while idle opens a receive
    '{OP_TICK,  1'b0, 24'hFFFFFF, 1'b1, {1'b1, 1'b0, 1'b1, 1'b0, 24'h000000}},
    // request while receiving is dropped
    '{OP_START, 1'b0, 24'hFFFFFF, 1'b1, {1'b1, 1'b0, 1'b1, 1'b0, 24'h000000}},
    // start pulse far too short: back to idle
    '{OP_TICK,  1'b1, 24'h000000, 1'b1, {1'b1, 1'b0, 1'b0, 1'b0, 24'h000000}},
    '{OP_TICK,  1'b0, 24'h000000, 1'b0, '0},
    '{OP_TICK,  1'b0, 24'hFFFFFF, 1'b0, '0},
    '{OP_TICK,  1'b1, 24'h000000, 1'b0, '0},
    // request while idle is taken and pulls the wire low at once
    '{OP_START, 1'b1, 24'hFFFFFF, 1'b1, {1'b0, 1'b1, 1'b1, 1'b0, 24'h000000}},
    // request while sending is dropped
    '{OP_START, 1'b0, 24'h000000, 1'b1, {1'b0, 1'b0, 1'b1, 1'b0, 24'h000000}},
    // wire ignored while sending
    '{OP_TICK,  1'b0, 24'h5A5A5A, 1'b0, '0},
    '{OP_TICK,  1'b1, 24'hA5A5A5, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // result side: stall pattern and beat checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    link_beat_t want;
    link_beat_t seen;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {line_drive, start_taken, link_busy, frame_done, recv_bytes};
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat drive=%b taken=%b busy=%b done=%b bytes=%h",
                     seen.drive, seen.taken, seen.busy, seen.done, seen.bytes);
        end else begin
          want = due_results.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: exp drive=%b taken=%b busy=%b done=%b bytes=%h, got drive=%b taken=%b busy=%b done=%b bytes=%h",
                       want.drive, want.taken, want.busy, want.done, want.bytes,
                       seen.drive, seen.taken, seen.busy, seen.done, seen.bytes);
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    cfg_regs_t c;
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_TICK;
    line_level = 1'b1;
    send_bytes = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_START_LOW_TICKS;
    cfg_data   = '0;
    reset_link();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver a lot
    tx_idle_pct  = 20;
    rx_stall_pct = 77;
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].lvl, dir_rows[i].data,
                dir_rows[i].has_want, dir_rows[i].want);
    // finish the frame started above, then one receive at reset timing
    settle_link();
    rx_frame(0);
    settle_link();

    // shortest timing; zero phase limits end after a single tick
    c = '{start_low_ticks: 8'd0, one_high_ticks: 8'd1, zero_high_ticks: 8'd1,
          one_low_ticks: 8'd0, zero_low_ticks: 8'd1, rx_start_min: 8'd0,
          rx_start_max: 8'd4, rx_one_min: 8'd0};
    load_cfg(c);
    run_phase(150);

    // roles swapped: sender idles a lot, receiver a little
    tx_idle_pct  = 77;
    rx_stall_pct = 20;
    load_cfg(short_timing_cfg());
    run_phase(200);

    // longest timing: full start pulse and one-bit phases, counter saturation
    c = '{start_low_ticks: 8'd255, one_high_ticks: 8'd255, zero_high_ticks: 8'd1,
          one_low_ticks: 8'd1, zero_low_ticks: 8'd2, rx_start_min: 8'd255,
          rx_start_max: 8'd255, rx_one_min: 8'd255};
    load_cfg(c);
    tx_frame(24'h000001 << $urandom_range(0, DATA_W - 1));
    rx_frame(260);
    settle_link();

    // no idling, plus the long receiver hold-off
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    load_cfg(short_timing_cfg());
    hold_req <= 1'b1;
    run_phase(250);

    // empty start window: every start pulse rejected
    c = short_timing_cfg();
    c.rx_start_min = 8'd20;
    c.rx_start_max = 8'd3;
    c.rx_one_min   = 8'd12;
    load_cfg(c);
    run_phase(100);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pwst_pkg.sv
sv/pulse_width_single_wire_transceiver_unit.sv
sv/pwst_checker.sv
sim/tb_pulse_width_single_wire_transceiver_unit.sv
